[design/burh_pkg.sv]
// ----------------------------------------------------------------------------
// burh_pkg
// Shared types and constants of the bounded undo/redo history block.
// ----------------------------------------------------------------------------
package burh_pkg;

	localparam int HIST_DEPTH  = 10;
	localparam int CNT_W       = $clog2(HIST_DEPTH + 1);
	localparam int IDX_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_UNDO = 8'h55;
	localparam logic [7:0] CHAR_REDO = 8'h52;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_LO_Z = 8'h7a;

	localparam logic [2:0] KIND_HIST       = 3'd0;
	localparam logic [2:0] KIND_HIST_EMPTY = 3'd1;
	localparam logic [2:0] KIND_REDO       = 3'd2;
	localparam logic [2:0] KIND_REDO_EMPTY = 3'd3;
	localparam logic [2:0] KIND_ERROR      = 3'd4;

	typedef enum logic [1:0] {
		OP_LETTER = 2'd0,
		OP_UNDO   = 2'd1,
		OP_REDO   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] letter;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

endpackage

[design/burh_front.sv]
// ----------------------------------------------------------------------------
// burh_front
// Accepts input items, classifies them into operations and queues them.
// ----------------------------------------------------------------------------
module burh_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            action,
	input  logic [7:0]      char_code,
	input  logic            pop,
	output logic            busy,
	output burh_pkg::q_head_t head
);
	import burh_pkg::*;

	q_item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                accept;
	logic                push;
	q_item_t             item;

	// Bytes that carry no operation are taken and dropped here.
	always_comb begin
		item.letter = char_code;
		item.op     = OP_LETTER;
		push        = 1'b0;
		if (action) begin
			item.op = OP_END;
			push    = accept;
		end else if (char_code == CHAR_UNDO) begin
			item.op = OP_UNDO;
			push    = accept;
		end else if (char_code == CHAR_REDO) begin
			item.op = OP_REDO;
			push    = accept;
		end else if (char_code >= CHAR_LO_A && char_code <= CHAR_LO_Z) begin
			push = accept;
		end
	end

	assign busy       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign accept     = start && !busy;
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= item;
		end
	end

endmodule

[design/burh_back.sv]
// ----------------------------------------------------------------------------
// burh_back
// Holds the history and redo stacks, executes queued operations and
// sequences the dump of an end item one result per cycle.
// ----------------------------------------------------------------------------
module burh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  burh_pkg::q_head_t    head,
	output logic                 pop,
	output logic                 strobe,
	output logic [2:0]           kind,
	output logic [7:0]           letter,
	output logic                 last
);
	import burh_pkg::*;

	typedef enum logic [2:0] {
		S_RUN  = 3'b001,
		S_HIST = 3'b010,
		S_REDO = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [7:0]         hist_q [HIST_DEPTH];
	logic [7:0]         redo_q [HIST_DEPTH];
	logic [CNT_W-1:0]   hcnt_q, hcnt_d;
	logic [CNT_W-1:0]   rcnt_q, rcnt_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               halted_q, halted_d;
	logic               h_push, h_pop, r_push, r_pop, r_clear, clear_all;
	logic [7:0]         h_in, r_in;
	logic               out_valid, out_last;
	logic [2:0]         out_kind;
	logic [7:0]         out_letter;
	logic               hist_end, redo_end;

	assign hist_end = (CNT_W'(idx_q) == hcnt_q - CNT_W'(1));
	assign redo_end = (CNT_W'(idx_q) == rcnt_q - CNT_W'(1));
	assign pop      = (state_q == S_RUN) && head.valid;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		halted_d   = halted_q;
		h_push     = 1'b0;
		h_pop      = 1'b0;
		r_push     = 1'b0;
		r_pop      = 1'b0;
		r_clear    = 1'b0;
		clear_all  = 1'b0;
		h_in       = head.item.letter;
		r_in       = hist_q[0];
		out_valid  = 1'b0;
		out_kind   = KIND_ERROR;
		out_letter = '0;
		out_last   = 1'b0;
		case (state_q)
			S_RUN: begin
				if (head.valid) begin
					if (head.item.op == OP_END) begin
						if (halted_q) begin
							clear_all = 1'b1;
						end else begin
							state_d = S_HIST;
							idx_d   = '0;
						end
					end else if (!halted_q) begin
						case (head.item.op)
							OP_UNDO: begin
								if (hcnt_q == '0) begin
									out_valid = 1'b1;
									out_last  = 1'b1;
									halted_d  = 1'b1;
								end else begin
									h_pop  = 1'b1;
									r_push = 1'b1;
								end
							end
							OP_REDO: begin
								if (rcnt_q == '0) begin
									out_valid = 1'b1;
									out_last  = 1'b1;
									halted_d  = 1'b1;
								end else begin
									r_pop  = 1'b1;
									h_push = 1'b1;
									h_in   = redo_q[0];
								end
							end
							OP_LETTER: begin
								r_clear = 1'b1;
								h_push  = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_HIST: begin
				out_valid = 1'b1;
				if (hcnt_q == '0) begin
					out_kind = KIND_HIST_EMPTY;
					state_d  = S_REDO;
					idx_d    = '0;
				end else begin
					out_kind   = KIND_HIST;
					out_letter = hist_q[idx_q];
					if (hist_end) begin
						state_d = S_REDO;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			S_REDO: begin
				out_valid = 1'b1;
				if (rcnt_q == '0) begin
					out_kind  = KIND_REDO_EMPTY;
					out_last  = 1'b1;
					clear_all = 1'b1;
					state_d   = S_RUN;
				end else begin
					out_kind   = KIND_REDO;
					out_letter = redo_q[idx_q];
					if (redo_end) begin
						out_last  = 1'b1;
						clear_all = 1'b1;
						state_d   = S_RUN;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
		if (clear_all) begin
			halted_d = 1'b0;
		end
	end

	always_comb begin
		hcnt_d = hcnt_q;
		if (clear_all) begin
			hcnt_d = '0;
		end else if (h_push) begin
			hcnt_d = (hcnt_q == CNT_W'(HIST_DEPTH)) ? hcnt_q : hcnt_q + CNT_W'(1);
		end else if (h_pop) begin
			hcnt_d = hcnt_q - CNT_W'(1);
		end
		rcnt_d = rcnt_q;
		if (clear_all || r_clear) begin
			rcnt_d = '0;
		end else if (r_push) begin
			rcnt_d = (rcnt_q == CNT_W'(HIST_DEPTH)) ? rcnt_q : rcnt_q + CNT_W'(1);
		end else if (r_pop) begin
			rcnt_d = rcnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RUN;
			hcnt_q   <= '0;
			rcnt_q   <= '0;
			idx_q    <= '0;
			halted_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			state_q  <= state_d;
			hcnt_q   <= hcnt_d;
			rcnt_q   <= rcnt_d;
			idx_q    <= idx_d;
			halted_q <= halted_d;
			strobe   <= out_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind   <= out_kind;
		letter <= out_letter;
		last   <= out_last;
		if (h_push) begin
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= h_in;
		end else if (h_pop) begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
		end
		if (r_push) begin
			for (int i = 1; i < HIST_DEPTH; i++) begin
				redo_q[i] <= redo_q[i-1];
			end
			redo_q[0] <= r_in;
		end else if (r_pop) begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				redo_q[i] <= redo_q[i+1];
			end
		end
	end

endmodule

[design/bounded_undo_redo_history.sv]
// ----------------------------------------------------------------------------
// bounded_undo_redo_history
// Bounded undo history of lowercase letters with a redo stack and a dump on
// each end item that does not follow an error.
// ----------------------------------------------------------------------------
// An item transfers when start is high and busy is low; busy rises only when
// the four-entry command queue is full. The execution unit executes each
// character as it reaches the queue head. Unless an error has halted the unit,
// an end item starts a dump of the history, then of the redo stack, each
// giving an empty marker when it is empty; the dump sequencer reads one
// stored entry per cycle. Results leave one per cycle, each valid for exactly
// one cycle with strobe high, and the receiver cannot stall them.
module bounded_undo_redo_history (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       action,
	input  logic [7:0] char_code,
	output logic       strobe,
	output logic [2:0] kind,
	output logic [7:0] letter,
	output logic       last
);
	import burh_pkg::*;

	q_head_t head;
	logic    pop;

	burh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.char_code (char_code),
		.pop       (pop),
		.busy      (busy),
		.head      (head)
	);

	burh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.kind   (kind),
		.letter (letter),
		.last   (last)
	);

endmodule

[design/burh_checker.sv]
// ----------------------------------------------------------------------------
// burh_checker
// Port-level checks on the result stream of the undo/redo history block.
// ----------------------------------------------------------------------------
module burh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       action,
	input logic [7:0] char_code,
	input logic       strobe,
	input logic [2:0] kind,
	input logic [7:0] letter,
	input logic       last
);
	import burh_pkg::*;

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_ERROR |-> last)
		else $error("error result without last");

	a_hist_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_HIST || kind == KIND_HIST_EMPTY) |-> !last)
		else $error("history result marked last");

	a_redo_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_REDO_EMPTY |-> last)
		else $error("redo empty marker without last");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_HIST_EMPTY || kind == KIND_REDO_EMPTY ||
		kind == KIND_ERROR) |-> letter == 8'd0)
		else $error("marker result with nonzero letter");

	a_hist_empty_next: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_HIST_EMPTY |=>
		strobe && (kind == KIND_REDO || kind == KIND_REDO_EMPTY))
		else $error("history empty marker not followed by redo part");

endmodule

bind bounded_undo_redo_history burh_checker u_burh_checker (.*);
